>>> src/ptc_pkg.sv
// Shared constants and types for the planar tile to chunky row decoder.
package ptc_pkg;

  localparam int ROW_PIXELS  = 8;
  localparam int PAIR_BYTES  = 16;
  localparam int MAX_PAIRS   = 4;
  localparam int PLANES      = 2 * MAX_PAIRS;
  localparam int STORE_W     = 16 * (MAX_PAIRS - 1);
  localparam int POS_W       = 6;
  localparam int ROW_W       = 3;
  localparam int PAIR_W      = 2;
  localparam int CFG_W       = 3;
  localparam int OUT_DATA_W  = 72;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [STORE_W-1:0] store_row_t;

  // Decoded position of the current byte within its tile.
  typedef struct packed {
    pair_t pair;
    row_t  row;
    logic  odd;
    logic  last_pair;
  } tile_pos_t;

endpackage

>>> src/planar_tile_to_chunky_unit.sv
// Top level: planar tile bytes in, chunky pixel rows out, plane store in a row memory.
// A row is registered and presented in the cycle after the odd byte of its last plane pair is accepted.
// Throughput: one byte per cycle while the output is not stalled; the plane store is read on every even byte, so its
// registered row is ready when the odd byte of that pair arrives the cycle after or later.
// Reset (rst_n low, synchronous): plane_pairs returns to 2, tile position and pending
// plane byte clear, output empties; the plane store memory keeps its contents.
module planar_tile_to_chunky_unit
  import ptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] row, [10:3] pixel_0 .. [66:59] pixel_7
  output logic                  out_tlast,  // tile_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t       pairs_cfg_r;
  pos_t       pos_r, pos_nxt;
  byte_t      pend_r;
  store_row_t rd_data_r;
  store_row_t mem [ROW_PIXELS];

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic       in_fire;
  cfg_t       pairs;
  logic [6:0] tile_bytes;
  pos_t       pos;
  tile_pos_t  tp;
  logic [6:0] next_pos;
  logic       produce;
  logic       store_we;
  logic       store_re;
  byte_t      planes [PLANES];
  logic [OUT_DATA_W-1:0] row_data;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // zero acts as one, above the maximum clamps
  always_comb begin
    if (pairs_cfg_r == '0) begin
      pairs = cfg_t'(1);
    end else if (pairs_cfg_r > cfg_t'(MAX_PAIRS)) begin
      pairs = cfg_t'(MAX_PAIRS);
    end else begin
      pairs = pairs_cfg_r;
    end
  end

  assign tile_bytes = {pairs, 4'b0000};

  always_comb begin
    pos = in_tuser ? '0 : pos_r;
    if ({1'b0, pos} >= tile_bytes) begin
      pos = '0;
    end
    tp.pair      = pos[5:4];
    tp.row       = pos[3:1];
    tp.odd       = pos[0];
    tp.last_pair = ({1'b0, tp.pair} + cfg_t'(1)) == pairs;
    next_pos     = {1'b0, pos} + 7'd1;
    pos_nxt      = (next_pos >= tile_bytes) ? '0 : next_pos[POS_W-1:0];
  end

  assign produce  = in_fire && tp.odd && tp.last_pair;
  assign store_we = in_fire && tp.odd && !tp.last_pair;
  // Read on every even byte: the pair count may change before the odd byte arrives.
  assign store_re = in_fire && !tp.odd;

  // Reads happen on even bytes and writes on odd bytes, never at the same edge;
  // an odd byte follows the even byte of its own row, unless in_tuser or a pair count change restarts the tile.
  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PAIRS - 1; p++) begin
      if (store_we && tp.pair == pair_t'(p)) begin
        mem[tp.row][16*p +: 16] <= {in_tdata, pend_r};
      end
    end
    if (store_re) begin
      rd_data_r <= mem[tp.row];
    end
  end

  // plane k gives bit k of the pixel index
  always_comb begin
    for (int k = 0; k < PLANES; k++) begin
      if (4'(k) < {1'b0, tp.pair, 1'b0}) begin
        planes[k] = (k < STORE_W / 8) ? rd_data_r[8*(k % (STORE_W / 8)) +: 8] : '0;
      end else if (4'(k) == {1'b0, tp.pair, 1'b0}) begin
        planes[k] = pend_r;
      end else if (4'(k) == {1'b0, tp.pair, 1'b1}) begin
        planes[k] = in_tdata;
      end else begin
        planes[k] = '0;
      end
    end
    row_data = '0;
    row_data[ROW_W-1:0] = tp.row;
    for (int x = 0; x < ROW_PIXELS; x++) begin
      for (int k = 0; k < PLANES; k++) begin
        row_data[ROW_W + 8*x + k] = planes[k][7-x];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_cfg_r <= cfg_t'(2);
      pos_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pairs_cfg_r <= cfg_data;
      end
      if (in_fire) begin
        pos_r <= pos_nxt;
        if (!tp.odd) begin
          pend_r <= in_tdata;
        end
      end
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_data_r <= row_data;
      out_last_r <= (tp.row == row_t'(ROW_PIXELS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire))
    else $error("output appeared without an accepted byte");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    produce && tp.row == row_t'(ROW_PIXELS - 1) |=> out_tlast && out_tdata[2:0] == 3'd7)
    else $error("last row of tile not flagged");

  a_pending_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !tp.odd |=> pend_r == $past(in_tdata))
    else $error("even plane byte not held");
`endif

endmodule
